### rtl/core/lif_pkg.sv
`timescale 1ns / 1ps

package lif_pkg;

    // Membrane store geometry. The neuron index is used directly as the
    // store address, so the store depth equals the index range.
    localparam int LIF_ID_W    = 10;
    localparam int LIF_NEURONS = 1024;
    localparam int LIF_ADDR_W  = $clog2(LIF_NEURONS);

    localparam int LIF_VOLT_W  = 16;
    localparam int LIF_RATE_W  = 16;
    localparam int LIF_GAIN_W  = 15;
    localparam int LIF_CFG_IDX_W  = 3;
    localparam int LIF_CFG_DATA_W = 16;

    typedef logic signed [LIF_VOLT_W-1:0] t_volt;
    typedef logic [LIF_RATE_W-1:0]        t_rate;
    typedef logic [LIF_GAIN_W-1:0]        t_gain;
    typedef logic [LIF_ID_W-1:0]          t_id;

    typedef enum logic [LIF_CFG_IDX_W-1:0] {
        CFG_DT_OVER_TAU = 3'd0,
        CFG_V_THRESHOLD = 3'd1,
        CFG_V_FLOOR     = 3'd2,
        CFG_NOISE_RATE  = 3'd3,
        CFG_NOISE_GAIN  = 3'd4
    } t_cfg_idx;

    localparam t_rate RST_DT_OVER_TAU = 16'd6554;
    localparam t_volt RST_V_THRESHOLD = 16'sd256;
    localparam t_volt RST_V_FLOOR     = -16'sd32768;
    localparam t_rate RST_NOISE_RATE  = 16'd0;
    localparam t_gain RST_NOISE_GAIN  = 15'd0;

endpackage

### rtl/core/lif_ram.sv
`timescale 1ns / 1ps

module lif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to the same address in one cycle
    // return the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lif_neuron_update_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Word
// -------   ---------  ---------------------------  ---------------------------------------
// command   in         start & !busy                neuron_id, drive, gate/noise random
// result    out        o_valid, one-cycle strobe    neuron_out, spike, membrane
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command per cycle while busy is low; each passes through stages A, B, C and the result registers in turn.
// Two commands for the same neuron in consecutive cycles stall the pipeline:
// the second waits in stage B for the first one's write-back.
// After reset a clearing pass writes zero to all 1024 store entries, one per
// cycle, with busy high; configuration writes are taken during it.
// Results cannot be held off, so nothing else stalls the pipeline.

module lif_neuron_update_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lif_pkg::t_id                        i_neuron_id,
    input  lif_pkg::t_volt                      i_drive,
    input  lif_pkg::t_rate                      i_gate_random,
    input  lif_pkg::t_rate                      i_noise_random,
    output logic                                o_valid,
    output lif_pkg::t_id                        o_neuron_out,
    output logic                                o_spike,
    output lif_pkg::t_volt                      o_membrane,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lif_pkg::LIF_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lif_pkg::LIF_CFG_DATA_W-1:0]  i_cfg_data
);

    import lif_pkg::*;

    // Configuration.
    t_rate r_dt;
    t_volt r_thr;
    t_volt r_floor;
    t_rate r_rate;
    t_gain r_gain;

    // Clearing pass.
    logic                  r_clearing;
    logic [LIF_ADDR_W-1:0] r_clr_addr;

    // Stage A: noise product formed at accept.
    logic               r_a_valid;
    t_id                r_a_id;
    t_volt              r_a_drive;
    logic signed [31:0] r_a_nprod;

    // Stage B: drive plus noise, waits for the stored voltage.
    logic               r_b_valid;
    t_id                r_b_id;
    logic signed [17:0] r_b_sum;

    // Stage C: leak product, then round, clamp, fire and write back.
    logic               r_c_valid;
    t_id                r_c_id;
    t_volt              r_c_v;
    logic signed [35:0] r_c_prod;

    // Result registers; they also forward the latest write-back.
    logic  r_o_valid;
    t_id   r_o_id;
    logic  r_o_spike;
    t_volt r_o_v;

    logic               accept;
    logic               stall;
    logic signed [16:0] noise_m;
    logic signed [32:0] nprod_full;
    logic signed [31:0] n_a_nprod;
    logic signed [32:0] nround;
    logic signed [16:0] noise;
    logic signed [17:0] n_b_sum;
    t_volt              ram_q;
    t_volt              v_b;
    logic signed [18:0] diff;
    logic signed [35:0] n_c_prod;
    logic signed [36:0] dround;
    logic signed [20:0] delta;
    logic signed [21:0] vn;
    logic signed [21:0] v_floored;
    t_volt              v_sat;
    logic               n_o_spike;
    t_volt              n_o_v;
    logic                  ram_we;
    logic [LIF_ADDR_W-1:0] ram_waddr;
    t_volt                 ram_wdata;

    // The item in stage B needs the voltage that stage C is still computing.
    assign stall  = r_b_valid && r_c_valid && (r_c_id == r_b_id);
    assign busy   = r_clearing || (r_a_valid && stall);
    assign accept = start && !busy;
    assign o_cfg_ready = 1'b1;

    // 2*noise_random - 65536: the top bit of the doubled word flips.
    assign noise_m    = $signed({~i_noise_random[15], i_noise_random[14:0], 1'b0});
    assign nprod_full = $signed({1'b0, r_gain}) * noise_m;
    assign n_a_nprod  = (i_gate_random < r_rate) ? nprod_full[31:0] : 32'sd0;

    assign nround  = $signed({r_a_nprod[31], r_a_nprod}) + 33'sd32768;
    assign noise   = nround[32:16];
    assign n_b_sum = $signed({noise[16], noise}) + $signed({{2{r_a_drive[15]}}, r_a_drive});

    // The memory word lags one write; the result register covers it.
    assign v_b      = (r_o_valid && (r_o_id == r_b_id)) ? r_o_v : ram_q;
    assign diff     = $signed({r_b_sum[17], r_b_sum}) - $signed({{3{v_b[15]}}, v_b});
    assign n_c_prod = $signed({1'b0, r_dt}) * diff;

    assign dround = $signed({r_c_prod[35], r_c_prod}) + 37'sd32768;
    assign delta  = dround[36:16];
    assign vn     = $signed({{6{r_c_v[15]}}, r_c_v}) + $signed({delta[20], delta});

    always_comb begin
        if (vn < $signed({{6{r_floor[15]}}, r_floor})) begin
            v_floored = $signed({{6{r_floor[15]}}, r_floor});
        end else begin
            v_floored = vn;
        end
        if (v_floored > 22'sd32767) begin
            v_sat = 16'sd32767;
        end else if (v_floored < -22'sd32768) begin
            v_sat = -16'sd32768;
        end else begin
            v_sat = v_floored[15:0];
        end
        n_o_spike = (v_sat > r_thr);
        n_o_v     = n_o_spike ? 16'sd0 : v_sat;
    end

    assign ram_we    = r_clearing || r_c_valid;
    assign ram_waddr = r_clearing ? r_clr_addr : r_c_id[LIF_ADDR_W-1:0];
    assign ram_wdata = r_clearing ? 16'sd0 : n_o_v;

    lif_ram #(
        .WIDTH (LIF_VOLT_W),
        .DEPTH (LIF_NEURONS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_a_id[LIF_ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_dt       <= RST_DT_OVER_TAU;
            r_thr      <= RST_V_THRESHOLD;
            r_floor    <= RST_V_FLOOR;
            r_rate     <= RST_NOISE_RATE;
            r_gain     <= RST_NOISE_GAIN;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LIF_ADDR_W'(LIF_NEURONS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (!(r_a_valid && stall)) begin
                r_a_valid <= accept;
            end
            if (!stall) begin
                r_b_valid <= r_a_valid;
            end
            r_c_valid <= r_b_valid && !stall;
            r_o_valid <= r_c_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DT_OVER_TAU: r_dt    <= i_cfg_data;
                    CFG_V_THRESHOLD: r_thr   <= $signed(i_cfg_data);
                    CFG_V_FLOOR:     r_floor <= $signed(i_cfg_data);
                    CFG_NOISE_RATE:  r_rate  <= i_cfg_data;
                    CFG_NOISE_GAIN:  r_gain  <= i_cfg_data[LIF_GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (!(r_a_valid && stall)) begin
            r_a_id    <= i_neuron_id;
            r_a_drive <= i_drive;
            r_a_nprod <= n_a_nprod;
        end
        if (!stall) begin
            r_b_id  <= r_a_id;
            r_b_sum <= n_b_sum;
        end
        r_c_id    <= r_b_id;
        r_c_v     <= v_b;
        r_c_prod  <= n_c_prod;
        r_o_id    <= r_c_id;
        r_o_spike <= n_o_spike;
        r_o_v     <= n_o_v;
    end

    assign o_valid      = r_o_valid;
    assign o_neuron_out = r_o_id;
    assign o_spike      = r_o_spike;
    assign o_membrane   = r_o_v;

endmodule

### test/tb_lif_neuron_update_core.sv
`timescale 1ns / 1ps

module tb_lif_neuron_update_core;
    import lif_pkg::*;

    localparam longint Q16_ONE  = 65536;
    localparam longint Q16_HALF = 32768;
    localparam t_volt  VOLT_MIN = -16'sd32768;
    localparam t_volt  VOLT_MAX = 16'sd32767;
    localparam t_rate  RATE_MAX = 16'hFFFF;
    localparam t_gain  GAIN_MAX = 15'h7FFF;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     RANDOM_PHASES = 10;
    localparam int     ITEMS_PER_PHASE = 123;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [LIF_CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [LIF_CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct {
        t_id   neuron;
        logic  spike;
        t_volt membrane;
    } t_update;

    class membrane_board;
        t_rate   dt_over_tau;
        t_volt   v_threshold;
        t_volt   v_floor;
        t_rate   noise_rate;
        t_gain   noise_gain;
        t_volt   volts[LIF_NEURONS];
        t_update expected_updates[$];
        int      errors;

        function new();
            dt_over_tau = RST_DT_OVER_TAU;
            v_threshold = RST_V_THRESHOLD;
            v_floor     = RST_V_FLOOR;
            noise_rate  = RST_NOISE_RATE;
            noise_gain  = RST_NOISE_GAIN;
            foreach (volts[i]) volts[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [LIF_CFG_IDX_W-1:0] idx,
                              logic [LIF_CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DT_OVER_TAU: dt_over_tau = data;
                CFG_V_THRESHOLD: v_threshold = data;
                CFG_V_FLOOR:     v_floor     = data;
                CFG_NOISE_RATE:  noise_rate  = data;
                CFG_NOISE_GAIN:  noise_gain  = data[LIF_GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the new voltage for an accepted command and queues it.
        function void note_command(t_id id, t_volt drive, t_rate gate, t_rate nrand);
            int      addr;
            longint  v;
            longint  noise;
            longint  diff;
            t_update upd;
            addr  = int'(id) % LIF_NEURONS;
            v     = longint'(volts[addr]);
            noise = 0;
            if (gate < noise_rate) begin
                noise = (longint'(noise_gain) * (2 * longint'(nrand) - Q16_ONE)
                         + Q16_HALF) >>> 16;
            end
            diff = noise + longint'(drive) - v;
            v    = v + ((longint'(dt_over_tau) * diff + Q16_HALF) >>> 16);
            if (v < longint'(v_floor)) v = longint'(v_floor);
            if (v > longint'(VOLT_MAX)) v = longint'(VOLT_MAX);
            if (v < longint'(VOLT_MIN)) v = longint'(VOLT_MIN);
            upd.neuron = id;
            upd.spike  = (v > longint'(v_threshold));
            if (upd.spike) v = 0;
            upd.membrane = t_volt'(v);
            volts[addr]  = upd.membrane;
            expected_updates.push_back(upd);
        endfunction

        function void check_update(t_id id, logic spike, t_volt membrane);
            t_update exp_upd;
            if (expected_updates.size() == 0) begin
                $error("result for neuron %0d with no command waiting", id);
                errors++;
                return;
            end
            exp_upd = expected_updates.pop_front();
            if (id !== exp_upd.neuron) begin
                $error("neuron_out mismatch: expected %0d, actual %0d", exp_upd.neuron, id);
                errors++;
            end
            if (spike !== exp_upd.spike) begin
                $error("spike mismatch: expected %0d, actual %0d", exp_upd.spike, spike);
                errors++;
            end
            if (membrane !== exp_upd.membrane) begin
                $error("membrane mismatch: expected %0d, actual %0d",
                       exp_upd.membrane, membrane);
                errors++;
            end
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    t_id                         i_neuron_id = '0;
    t_volt                       i_drive = '0;
    t_rate                       i_gate_random = '0;
    t_rate                       i_noise_random = '0;
    logic                        o_valid;
    t_id                         o_neuron_out;
    logic                        o_spike;
    t_volt                       o_membrane;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [LIF_CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [LIF_CFG_DATA_W-1:0]   i_cfg_data = '0;

    membrane_board board;

    lif_neuron_update_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_neuron_id    (i_neuron_id),
        .i_drive        (i_drive),
        .i_gate_random  (i_gate_random),
        .i_noise_random (i_noise_random),
        .o_valid        (o_valid),
        .o_neuron_out   (o_neuron_out),
        .o_spike        (o_spike),
        .o_membrane     (o_membrane),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_update(o_neuron_out, o_spike, o_membrane);
        end
    end

    // Every task is entered and left right after a rising edge.
    task automatic issue(input t_id id, input t_volt drv, input t_rate gate,
                         input t_rate nrand);
        start          <= 1'b1;
        i_neuron_id    <= id;
        i_drive        <= drv;
        i_gate_random  <= gate;
        i_noise_random <= nrand;
        do @(posedge i_clk); while (busy);
        board.note_command(id, drv, gate, nrand);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the valid high so that writes can follow back to back.
    task automatic write_reg(input logic [LIF_CFG_IDX_W-1:0] idx,
                             input logic [LIF_CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic randomize_config();
        logic [LIF_CFG_IDX_W-1:0] spare;
        spare = LIF_CFG_IDX_W'(CFG_SPARE_FIRST
                + $urandom_range(0, CFG_SPARE_LAST - CFG_SPARE_FIRST));
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_DT_OVER_TAU, 16'd0);
            1:       write_reg(CFG_DT_OVER_TAU, RATE_MAX);
            default: write_reg(CFG_DT_OVER_TAU,
                               LIF_CFG_DATA_W'($urandom_range(2000, 40000)));
        endcase
        case ($urandom_range(0, 5))
            0:       write_reg(CFG_V_THRESHOLD, VOLT_MIN);
            1:       write_reg(CFG_V_THRESHOLD, VOLT_MAX);
            default: write_reg(CFG_V_THRESHOLD, t_volt'(int'($urandom_range(0, 1024)) - 256));
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_V_FLOOR, LIF_CFG_DATA_W'($urandom));
            1:       write_reg(CFG_V_FLOOR, t_volt'(-int'($urandom_range(0, 1024))));
            default: write_reg(CFG_V_FLOOR, VOLT_MIN);
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_NOISE_RATE, 16'd0);
            1:       write_reg(CFG_NOISE_RATE, RATE_MAX);
            default: write_reg(CFG_NOISE_RATE, LIF_CFG_DATA_W'($urandom));
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_NOISE_GAIN, 16'd0);
            1:       write_reg(CFG_NOISE_GAIN, LIF_CFG_DATA_W'(GAIN_MAX));
            2:       write_reg(CFG_NOISE_GAIN, LIF_CFG_DATA_W'($urandom));
            default: write_reg(CFG_NOISE_GAIN, LIF_CFG_DATA_W'($urandom_range(0, 4096)));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            write_reg(spare, LIF_CFG_DATA_W'($urandom));
        end
        end_writes();
    endtask

    // Most commands revisit a few neurons so that voltages build up and the
    // same neuron often comes back to back.
    task automatic issue_random(input int pool_base);
        t_id   id;
        t_volt drv;
        if ($urandom_range(0, 9) < 7) begin
            id = t_id'(pool_base + $urandom_range(0, 3));
        end else begin
            id = t_id'($urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
            drv = t_volt'($urandom);
        end else begin
            drv = t_volt'(int'($urandom_range(0, 3072)) - 1536);
        end
        issue(id, drv, t_rate'($urandom), t_rate'($urandom));
    endtask

    task automatic run_random(input int count);
        int left;
        int burst;
        int pool_base;
        left      = count;
        pool_base = $urandom_range(0, LIF_NEURONS - 1);
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) issue_random(pool_base);
            left -= burst;
            if ($urandom_range(0, 15) == 0) begin
                drain();
            end else begin
                pause($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register reset values: no noise even with a zero gate word.
        issue(10'd0, VOLT_MAX, 16'd0, 16'd0);
        issue(10'd1023, VOLT_MIN, RATE_MAX, RATE_MAX);
        issue(10'd1023, VOLT_MIN, 16'd0, 16'd0);
        issue(10'd1023, VOLT_MIN, 16'd0, 16'd0);
        issue(10'd5, 16'sd1000, 16'd100, 16'd200);
        issue(10'd5, 16'sd1000, 16'd100, 16'd200);
        pause(1);
        issue(10'd5, 16'sd0, 16'd0, 16'd0);
        issue(10'd0, 16'sd0, RATE_MAX, 16'd0);
        drain();

        // Fastest leak, strongest noise, threshold out of reach: saturation.
        write_reg(CFG_DT_OVER_TAU, RATE_MAX);
        write_reg(CFG_V_THRESHOLD, VOLT_MAX);
        write_reg(CFG_V_FLOOR, VOLT_MIN);
        write_reg(CFG_NOISE_RATE, RATE_MAX);
        write_reg(CFG_NOISE_GAIN, LIF_CFG_DATA_W'(GAIN_MAX));
        write_reg(CFG_SPARE_FIRST, 16'hFFFF);
        end_writes();
        issue(10'd0, VOLT_MAX, 16'd0, RATE_MAX);
        issue(10'd0, VOLT_MAX, 16'd0, RATE_MAX);
        issue(10'd1, VOLT_MIN, 16'd0, 16'd0);
        issue(10'd2, 16'sd0, 16'd65534, 16'd32768);
        issue(10'd3, 16'sd0, RATE_MAX, 16'd0);
        issue(10'd4, 16'sd100, 16'd0, 16'd32767);
        issue(10'd1023, VOLT_MAX, RATE_MAX, 16'd0);
        drain();

        // Frozen leak, floor at the top, every neuron fires.
        write_reg(CFG_DT_OVER_TAU, 16'd0);
        write_reg(CFG_V_THRESHOLD, VOLT_MIN);
        write_reg(CFG_V_FLOOR, VOLT_MAX);
        write_reg(CFG_NOISE_RATE, 16'd0);
        write_reg(CFG_NOISE_GAIN, 16'd0);
        write_reg(CFG_SPARE_LAST, 16'h0000);
        end_writes();
        issue(10'd0, 16'sd0, 16'd0, 16'd0);
        issue(10'd1, VOLT_MAX, 16'd0, RATE_MAX);
        issue(10'd1023, VOLT_MIN, 16'd0, 16'd0);
        drain();

        repeat (RANDOM_PHASES) begin
            randomize_config();
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("lif_neuron_update_core test passed");
        end else begin
            $display("lif_neuron_update_core test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lif_neuron_update_core test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/lif_pkg.sv
rtl/core/lif_ram.sv
rtl/core/lif_neuron_update_core.sv
test/tb_lif_neuron_update_core.sv
